@@ hdl/abde_pkg.sv @@
// Package for the alpha blending draw engine: sizes, tdata widths, codes and
// the divide-by-255 helper. No dependencies.
`default_nettype none

package abde_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);

  localparam int DIM_W   = 9;
  localparam int RGB_W   = 24;
  localparam int COLOR_W = 32;
  localparam int COORD_W = 16;
  localparam int CMD_W   = 3;
  localparam int CNT_W   = 17;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BG     = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 9'd256;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 9'd256;
  localparam logic [RGB_W-1:0] BG_RST     = 24'hffffff;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 3'd0,
    CMD_HLINE   = 3'd1,
    CMD_VLINE   = 3'd2,
    CMD_OUTLINE = 3'd3,
    CMD_FILL    = 3'd4,
    CMD_READ    = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_START,
    ST_RUN,
    ST_RDWAIT,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    SEG_NONE,
    SEG_HLINE,
    SEG_VLINE,
    SEG_FILL,
    SEG_CLEAR,
    SEG_READ
  } seg_t;

  // exact floor(v/255) for v up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
    return t[15:8];
  endfunction

endpackage

`default_nettype wire

@@ hdl/alpha_blend_draw_engine.sv @@
// Alpha blending draw engine top level: command sequencer, clipping, frame
// memory and the blend pipeline. Depends on abde_pkg.
`default_nettype none

// Owns a 256x256 RGB frame memory (single write port, one registered read
// port) and takes one drawing command per input transaction, returning one
// result each. The memory holds no defined contents after reset: issue a clear
// before anything is drawn or read. Drawing walks the clipped shape one pixel
// per cycle through a read, multiply, divide-and-write pipeline; the first read
// of a segment waits until the pipeline has written back the previous segment,
// so that it sees the earlier writes. The next command is taken while a result
// still waits at out_.
module alpha_blend_draw_engine (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // command[2:0], x_pos[18:3], y_pos[34:19], span_width[50:35],
  // span_height[66:51], draw_color[98:67], zero fill up to bit 103
  input  wire  [abde_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // pixels_touched[16:0], read_data[40:17], read_in_range[41], zero fill
  output logic [abde_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [abde_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [abde_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW = abde_pkg::ADDR_W;
  localparam int DW = abde_pkg::DIM_W;
  localparam int CW = abde_pkg::COORD_W;

  abde_pkg::state_t state_r, state_nxt;

  // configuration
  logic [DW-1:0]              fw_r, fh_r;
  logic [abde_pkg::RGB_W-1:0] bg_r;
  logic [DW-1:0]              act_w, act_h;

  // command registers
  abde_pkg::cmd_t               cmd_r;
  logic [CW-1:0]                x_r, y_r, w_r, h_r;
  logic [abde_pkg::COLOR_W-1:0] color_r;
  logic [1:0]                   seg_r;
  logic [1:0]                   last_seg;

  // segment clip
  abde_pkg::seg_t  seg_kind, kind_r;
  logic [CW-1:0]   seg_x, seg_y;
  logic [DW-1:0]   rem_w, rem_h, min_w, min_h, clip_w, clip_h;
  logic            clip_ok, seg_go;
  logic [DW-1:0]   cw_r, ch_r;
  logic [abde_pkg::COL_W-1:0] sx_r, col_r;
  logic [abde_pkg::ROW_W-1:0] sy_r, row_r;
  logic [AW-1:0]   row_addr_r, pix_addr;
  logic            last_col, last_row;

  // result
  logic [abde_pkg::CNT_W-1:0] cnt_r;
  logic [abde_pkg::RGB_W-1:0] res_rd_r;
  logic                       res_rin_r;
  logic                       out_valid_r;
  logic [abde_pkg::OUT_TDATA_W-1:0] out_data_r;

  // memory and blend pipeline
  logic [abde_pkg::RGB_W-1:0] frame_mem [abde_pkg::STORE_DEPTH];
  logic [abde_pkg::RGB_W-1:0] rd_data_r;
  logic                       p1_v_r, p2_v_r;
  logic [AW-1:0]              p1_addr_r, p2_addr_r;
  logic [15:0]                p2_sum_r [3];
  logic                       mem_re, mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [abde_pkg::RGB_W-1:0] mem_wdata;
  logic                       pipe_busy;

  // sequencer strobes
  logic in_acc, seg_load, seg_skip, run_start, pix_step, blend_rd, clr_wr;
  logic rd_capture, out_load;

  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign pipe_busy = p1_v_r || p2_v_r;

  assign act_w = (fw_r > DW'(abde_pkg::MAX_WIDTH))  ? DW'(abde_pkg::MAX_WIDTH)  : fw_r;
  assign act_h = (fh_r > DW'(abde_pkg::MAX_HEIGHT)) ? DW'(abde_pkg::MAX_HEIGHT) : fh_r;

  assign last_seg = (cmd_r == abde_pkg::CMD_OUTLINE) ? 2'd3 : 2'd0;

  always_comb begin
    seg_kind = abde_pkg::SEG_NONE;
    seg_x    = x_r;
    seg_y    = y_r;
    case (cmd_r)
      abde_pkg::CMD_CLEAR: begin
        seg_kind = abde_pkg::SEG_CLEAR;
        seg_x    = '0;
        seg_y    = '0;
      end
      abde_pkg::CMD_HLINE: seg_kind = abde_pkg::SEG_HLINE;
      abde_pkg::CMD_VLINE: seg_kind = abde_pkg::SEG_VLINE;
      abde_pkg::CMD_OUTLINE: begin
        case (seg_r)
          2'd0: seg_kind = abde_pkg::SEG_HLINE;
          2'd1: seg_kind = abde_pkg::SEG_VLINE;
          2'd2: begin
            seg_kind = abde_pkg::SEG_HLINE;
            seg_y    = CW'(y_r + h_r - 16'd1);
          end
          default: begin
            seg_kind = abde_pkg::SEG_VLINE;
            seg_x    = CW'(x_r + w_r - 16'd1);
          end
        endcase
      end
      abde_pkg::CMD_FILL: seg_kind = abde_pkg::SEG_FILL;
      abde_pkg::CMD_READ: seg_kind = abde_pkg::SEG_READ;
      default:            seg_kind = abde_pkg::SEG_NONE;
    endcase
  end

  always_comb begin
    rem_w  = act_w - seg_x[DW-1:0];
    rem_h  = act_h - seg_y[DW-1:0];
    min_w  = (w_r < CW'(rem_w)) ? w_r[DW-1:0] : rem_w;
    min_h  = (h_r < CW'(rem_h)) ? h_r[DW-1:0] : rem_h;
    clip_ok = 1'b0;
    clip_w  = '0;
    clip_h  = '0;
    case (seg_kind)
      abde_pkg::SEG_HLINE: begin
        clip_ok = (seg_y < CW'(act_h)) && (seg_x <= CW'(act_w));
        clip_w  = min_w;
        clip_h  = DW'(1);
      end
      abde_pkg::SEG_VLINE: begin
        clip_ok = (seg_x < CW'(act_w)) && (seg_y <= CW'(act_h));
        clip_w  = DW'(1);
        clip_h  = min_h;
      end
      abde_pkg::SEG_FILL: begin
        clip_ok = (seg_x < CW'(act_w)) && (seg_y < CW'(act_h));
        clip_w  = min_w;
        clip_h  = min_h;
      end
      abde_pkg::SEG_CLEAR: begin
        clip_ok = 1'b1;
        clip_w  = act_w;
        clip_h  = act_h;
      end
      abde_pkg::SEG_READ: begin
        clip_ok = (seg_x < CW'(act_w)) && (seg_y < CW'(act_h));
        clip_w  = DW'(1);
        clip_h  = DW'(1);
      end
      default: clip_ok = 1'b0;
    endcase
    seg_go = clip_ok && (clip_w != '0) && (clip_h != '0);
  end

  assign pix_addr = row_addr_r + AW'(col_r);
  assign last_col = ({1'b0, col_r} == (cw_r - DW'(1)));
  assign last_row = ({1'b0, row_r} == (ch_r - DW'(1)));

  // next state and strobes
  always_comb begin
    state_nxt  = state_r;
    in_tready  = 1'b0;
    seg_load   = 1'b0;
    seg_skip   = 1'b0;
    run_start  = 1'b0;
    pix_step   = 1'b0;
    blend_rd   = 1'b0;
    clr_wr     = 1'b0;
    rd_capture = 1'b0;
    out_load   = 1'b0;
    mem_re     = 1'b0;
    case (state_r)
      abde_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = abde_pkg::ST_SETUP;
        end
      end
      abde_pkg::ST_SETUP: begin
        if (!pipe_busy) begin
          if (seg_go) begin
            seg_load  = 1'b1;
            state_nxt = abde_pkg::ST_START;
          end else if (seg_r == last_seg) begin
            state_nxt = abde_pkg::ST_FINISH;
          end else begin
            seg_skip = 1'b1;
          end
        end
      end
      abde_pkg::ST_START: begin
        run_start = 1'b1;
        state_nxt = abde_pkg::ST_RUN;
      end
      abde_pkg::ST_RUN: begin
        if (kind_r == abde_pkg::SEG_READ) begin
          mem_re    = 1'b1;
          state_nxt = abde_pkg::ST_RDWAIT;
        end else begin
          pix_step = 1'b1;
          if (kind_r == abde_pkg::SEG_CLEAR) begin
            clr_wr = 1'b1;
          end else begin
            blend_rd = 1'b1;
            mem_re   = 1'b1;
          end
          if (last_col && last_row) begin
            if (seg_r == last_seg) begin
              state_nxt = abde_pkg::ST_FINISH;
            end else begin
              seg_skip  = 1'b1;
              state_nxt = abde_pkg::ST_SETUP;
            end
          end
        end
      end
      abde_pkg::ST_RDWAIT: begin
        rd_capture = 1'b1;
        state_nxt  = abde_pkg::ST_FINISH;
      end
      abde_pkg::ST_FINISH: begin
        if (!pipe_busy && (!out_valid_r || out_tready)) begin
          out_load  = 1'b1;
          state_nxt = abde_pkg::ST_IDLE;
        end
      end
      default: state_nxt = abde_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= abde_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= abde_pkg::WIDTH_RST;
      fh_r <= abde_pkg::HEIGHT_RST;
      bg_r <= abde_pkg::BG_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        abde_pkg::REG_WIDTH:  fw_r <= cfg_data[DW-1:0];
        abde_pkg::REG_HEIGHT: fh_r <= cfg_data[DW-1:0];
        abde_pkg::REG_BG:     bg_r <= cfg_data[abde_pkg::RGB_W-1:0];
        default: ;
      endcase
    end
  end

  // command, segment and walk registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r     <= abde_pkg::cmd_t'(in_tdata[2:0]);
      x_r       <= in_tdata[18:3];
      y_r       <= in_tdata[34:19];
      w_r       <= in_tdata[50:35];
      h_r       <= in_tdata[66:51];
      color_r   <= in_tdata[98:67];
      seg_r     <= '0;
      cnt_r     <= '0;
      res_rd_r  <= '0;
      res_rin_r <= 1'b0;
    end
    if (seg_skip) begin
      seg_r <= seg_r + 2'd1;
    end
    if (seg_load) begin
      kind_r <= seg_kind;
      cw_r   <= clip_w;
      ch_r   <= clip_h;
      sx_r   <= seg_x[abde_pkg::COL_W-1:0];
      sy_r   <= seg_y[abde_pkg::ROW_W-1:0];
    end
    if (run_start) begin
      row_addr_r <= (AW'(sy_r) * AW'(act_w)) + AW'(sx_r);
      col_r      <= '0;
      row_r      <= '0;
    end
    if (pix_step) begin
      cnt_r <= cnt_r + abde_pkg::CNT_W'(1);
      if (last_col) begin
        col_r      <= '0;
        row_r      <= row_r + abde_pkg::ROW_W'(1);
        row_addr_r <= row_addr_r + AW'(act_w);
      end else begin
        col_r <= col_r + abde_pkg::COL_W'(1);
      end
    end
    if (rd_capture) begin
      res_rd_r  <= rd_data_r;
      res_rin_r <= 1'b1;
    end
  end

  // frame memory
  assign mem_we    = p2_v_r || clr_wr;
  assign mem_waddr = p2_v_r ? p2_addr_r : pix_addr;
  assign mem_wdata = p2_v_r ? {abde_pkg::div255(p2_sum_r[2]),
                               abde_pkg::div255(p2_sum_r[1]),
                               abde_pkg::div255(p2_sum_r[0])} : bg_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= frame_mem[pix_addr];
    end
  end

  // blend pipeline: read, multiply, divide and write back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else begin
      p1_v_r <= blend_rd;
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_addr_r <= pix_addr;
    p2_addr_r <= p1_addr_r;
    for (int c = 0; c < 3; c++) begin
      p2_sum_r[c] <= ({8'd0, color_r[31:24]} * {8'd0, color_r[c*8 +: 8]})
                   + ({8'd0, 8'hff - color_r[31:24]} * {8'd0, rd_data_r[c*8 +: 8]});
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {6'd0, res_rin_r, res_rd_r, cnt_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

@@ hdl/abde_checker.sv @@
// Port-level checker for the alpha blending draw engine and its bind.
// Depends on abde_pkg and the alpha_blend_draw_engine ports.
`default_nettype none

module abde_checker (
  input wire                                 clk,
  input wire                                 rst_n,
  input wire [abde_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input wire                                 out_tvalid,
  input wire                                 out_tready
);

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a read writes nothing
  a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[41] |-> out_tdata[16:0] == 17'd0)
    else $error("read reported pixel writes");

  a_read_data_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[40:17] != 24'd0) |-> out_tdata[41])
    else $error("read data without in-range flag");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[16] |-> out_tdata[15:0] == 16'd0)
    else $error("pixel count above frame size");

endmodule

bind alpha_blend_draw_engine abde_checker u_abde_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire

@@ sim/alpha_blend_draw_engine_tb.sv @@
// Self-checking testbench for alpha_blend_draw_engine: directed and random draw commands
// across several frame sizes, scored against a behavioural frame memory model.
// Depends on abde_pkg and the alpha_blend_draw_engine RTL.
`timescale 1ns / 1ps

module alpha_blend_draw_engine_tb;

  localparam int CMD_W       = abde_pkg::CMD_W;
  localparam int COORD_W     = abde_pkg::COORD_W;
  localparam int COLOR_W     = abde_pkg::COLOR_W;
  localparam int RGB_W       = abde_pkg::RGB_W;
  localparam int CNT_W       = abde_pkg::CNT_W;
  localparam int DIM_W       = abde_pkg::DIM_W;
  localparam int IN_TDATA_W  = abde_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = abde_pkg::OUT_TDATA_W;
  localparam int CFG_IDX_W   = abde_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = abde_pkg::CFG_DATA_W;
  localparam int MAX_WIDTH   = abde_pkg::MAX_WIDTH;
  localparam int MAX_HEIGHT  = abde_pkg::MAX_HEIGHT;
  localparam int STORE_DEPTH = abde_pkg::STORE_DEPTH;
  localparam int ADDR_W      = abde_pkg::ADDR_W;

  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
  localparam int MAX_REPORTS  = 10;
  localparam int IDLE_PCT     = 10;
  localparam int DRAIN_CYCLES = 64;
  localparam int PAD_W        = IN_TDATA_W - (CMD_W + 4 * COORD_W + COLOR_W);

  typedef struct {
    logic [CMD_W-1:0]   op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
    logic [COLOR_W-1:0] color;
  } draw_cmd_t;

  typedef struct {
    logic [CNT_W-1:0] touched;
    logic [RGB_W-1:0] pixel;
    logic             in_frame;
  } draw_result_t;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  // model of the frame memory and registers
  logic [RGB_W-1:0] frame_mem [STORE_DEPTH];
  logic [DIM_W-1:0] cfg_width  = abde_pkg::WIDTH_RST;
  logic [DIM_W-1:0] cfg_height = abde_pkg::HEIGHT_RST;
  logic [RGB_W-1:0] cfg_bg     = abde_pkg::BG_RST;
  int unsigned      touch_count;

  draw_cmd_t    pending_cmds [$];
  draw_result_t expected_results [$];
  draw_cmd_t    on_bus;
  draw_result_t drv_result;
  draw_result_t mon_expect;
  int unsigned  queued_count = 0;
  int unsigned  sent_count   = 0;
  int           error_count  = 0;
  longint       cycle_count  = 0;
  longint       cycle_limit  = 200000;
  logic         steady       = 1'b0;

  alpha_blend_draw_engine i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned active_w();
    return (cfg_width > MAX_WIDTH) ? MAX_WIDTH : {23'd0, cfg_width};
  endfunction

  function automatic int unsigned active_h();
    return (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : {23'd0, cfg_height};
  endfunction

  function automatic logic [RGB_W-1:0] blend_pixel(input logic [RGB_W-1:0] src,
                                                    input logic [RGB_W-1:0] dst,
                                                    input logic [7:0] alpha);
    logic [RGB_W-1:0] mixed;
    int unsigned      a, s, d;
    int               sh;
    a = {24'd0, alpha};
    for (sh = 0; sh <= 16; sh += 8) begin
      s = {24'd0, src[sh +: 8]};
      d = {24'd0, dst[sh +: 8]};
      mixed[sh +: 8] = 8'((a * s + (255 - a) * d) / 255);
    end
    return mixed;
  endfunction

  function automatic void plot_pixel(input int unsigned px, py,
                                     input logic [COLOR_W-1:0] color);
    int unsigned idx;
    idx = py * active_w() + px;
    if (idx < STORE_DEPTH)
      frame_mem[ADDR_W'(idx)] = blend_pixel(color[RGB_W-1:0], frame_mem[ADDR_W'(idx)],
                                            color[31:24]);
    touch_count++;
  endfunction

  function automatic void draw_row(input int unsigned px, py, len,
                                   input logic [COLOR_W-1:0] color);
    int unsigned fw, fh, n, i;
    fw = active_w();
    fh = active_h();
    n  = len;
    if (py >= fh || px > fw) return;
    if (px + n > fw) n = fw - px;
    for (i = 0; i < n; i++) plot_pixel(px + i, py, color);
  endfunction

  function automatic void draw_column(input int unsigned px, py, len,
                                      input logic [COLOR_W-1:0] color);
    int unsigned fw, fh, n, i;
    fw = active_w();
    fh = active_h();
    n  = len;
    if (px >= fw || py > fh) return;
    if (py + n > fh) n = fh - py;
    for (i = 0; i < n; i++) plot_pixel(px, py + i, color);
  endfunction

  function automatic void fill_block(input int unsigned px, py, bw, bh,
                                     input logic [COLOR_W-1:0] color);
    int unsigned fw, fh, nw, nh, i, j;
    fw = active_w();
    fh = active_h();
    nw = bw;
    nh = bh;
    if (px >= fw || py >= fh) return;
    if (py + nh > fh) nh = fh - py;
    if (px + nw > fw) nw = fw - px;
    for (j = 0; j < nh; j++)
      for (i = 0; i < nw; i++) plot_pixel(px + i, py + j, color);
  endfunction

  function automatic draw_result_t run_command(input draw_cmd_t c);
    draw_result_t r;
    int unsigned  fw, fh, n, i, x, y, w, h;
    fw = active_w();
    fh = active_h();
    x  = {16'd0, c.x};
    y  = {16'd0, c.y};
    w  = {16'd0, c.w};
    h  = {16'd0, c.h};
    r.pixel    = '0;
    r.in_frame = 1'b0;
    touch_count = 0;
    case (c.op)
      abde_pkg::CMD_CLEAR: begin
        n = fw * fh;
        for (i = 0; i < n && i < STORE_DEPTH; i++) frame_mem[ADDR_W'(i)] = cfg_bg;
        touch_count = n;
      end
      abde_pkg::CMD_HLINE: draw_row(x, y, w, c.color);
      abde_pkg::CMD_VLINE: draw_column(x, y, h, c.color);
      abde_pkg::CMD_OUTLINE: begin
        // corners are blended and counted twice
        draw_row(x, y, w, c.color);
        draw_column(x, y, h, c.color);
        draw_row(x, (y + h - 1) & 32'hffff, w, c.color);
        draw_column((x + w - 1) & 32'hffff, y, h, c.color);
      end
      abde_pkg::CMD_FILL: fill_block(x, y, w, h, c.color);
      abde_pkg::CMD_READ: begin
        if (x < fw && y < fh) begin
          r.in_frame = 1'b1;
          r.pixel    = frame_mem[ADDR_W'(y * fw + x)];
        end
      end
      default: ;
    endcase
    r.touched = touch_count[CNT_W-1:0];
    return r;
  endfunction

  function automatic draw_cmd_t make_cmd(input logic [CMD_W-1:0] op,
                                         input logic [COORD_W-1:0] x, y, w, h,
                                         input logic [COLOR_W-1:0] color);
    draw_cmd_t c;
    c.op    = op;
    c.x     = x;
    c.y     = y;
    c.w     = w;
    c.h     = h;
    c.color = color;
    return c;
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord(input int unsigned dim);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return COORD_W'($urandom_range(dim + 1, 0));
    if (r < 90) return COORD_W'($urandom_range(16'hffff, 0));
    case ($urandom_range(3))
      0:       return '0;
      1:       return (dim == 0) ? '0 : COORD_W'(dim - 1);
      2:       return COORD_W'(dim);
      default: return 16'hffff;
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_span(input int unsigned dim, cap);
    int unsigned r, lim;
    r   = $urandom_range(99);
    lim = (dim + 2 < cap) ? dim + 2 : cap;
    if (r < 70) return COORD_W'($urandom_range(lim, 0));
    if (r < 80) return '0;
    if (r < 90) return COORD_W'($urandom_range(16'hffff, 0));
    return $urandom_range(1) ? 16'hffff : COORD_W'(dim);
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    logic [7:0]       alpha;
    logic [RGB_W-1:0] rgb;
    int unsigned      r;
    r     = $urandom_range(99);
    alpha = (r < 20) ? 8'h00 : (r < 40) ? 8'hff : 8'($urandom);
    rgb   = RGB_W'($urandom);
    return {alpha, rgb};
  endfunction

  function automatic draw_cmd_t random_command(input int unsigned fw, fh, cap,
                                               input bit allow_clear);
    logic [CMD_W-1:0] op;
    int unsigned      r;
    r = $urandom_range(99);
    if (r < 4)       op = allow_clear ? abde_pkg::CMD_CLEAR : abde_pkg::CMD_READ;
    else if (r < 22) op = abde_pkg::CMD_HLINE;
    else if (r < 40) op = abde_pkg::CMD_VLINE;
    else if (r < 58) op = abde_pkg::CMD_OUTLINE;
    else if (r < 74) op = abde_pkg::CMD_FILL;
    else if (r < 94) op = abde_pkg::CMD_READ;
    else             op = $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;
    return make_cmd(op, pick_coord(fw), pick_coord(fh), pick_span(fw, cap),
                    pick_span(fh, cap), pick_color());
  endfunction

  function automatic void report_mismatch(input string what,
                                          input logic [47:0] want, got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
  endfunction

  task automatic queue_cmd(input draw_cmd_t c);
    pending_cmds.push_back(c);
    queued_count++;
  endtask

  task automatic wait_drained();
    while (sent_count != queued_count || expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      abde_pkg::REG_WIDTH:  cfg_width  = val[DIM_W-1:0];
      abde_pkg::REG_HEIGHT: cfg_height = val[DIM_W-1:0];
      abde_pkg::REG_BG:     cfg_bg     = val[RGB_W-1:0];
      default: ;
    endcase
  endtask

  task automatic run_phase(input int unsigned fw_req, fh_req,
                           input logic [RGB_W-1:0] bg,
                           input int unsigned count, cap,
                           input bit allow_clear);
    int unsigned fw, fh;
    write_reg(abde_pkg::REG_WIDTH, CFG_DATA_W'(fw_req));
    write_reg(abde_pkg::REG_HEIGHT, CFG_DATA_W'(fh_req));
    write_reg(abde_pkg::REG_BG, bg);
    fw = (fw_req > MAX_WIDTH) ? MAX_WIDTH : fw_req;
    fh = (fh_req > MAX_HEIGHT) ? MAX_HEIGHT : fh_req;
    queue_cmd(make_cmd(abde_pkg::CMD_CLEAR, COORD_W'($urandom), COORD_W'($urandom),
                       COORD_W'($urandom), COORD_W'($urandom), $urandom));
    repeat (count) queue_cmd(random_command(fw, fh, cap, allow_clear));
    wait_drained();
  endtask

  // command driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        drv_result = run_command(on_bus);
        expected_results.push_back(drv_result);
        cycle_limit += longint'(drv_result.touched) * 4 + 400;
        sent_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_cmds.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          on_bus = pending_cmds.pop_front();
          in_tdata  <= {{PAD_W{1'b0}}, on_bus.color, on_bus.h, on_bus.w,
                        on_bus.y, on_bus.x, on_bus.op};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result transaction", '0, out_tdata);
        end else begin
          mon_expect = expected_results.pop_front();
          if (out_tdata[CNT_W-1:0] !== mon_expect.touched)
            report_mismatch("pixels_touched", 48'(mon_expect.touched),
                            48'(out_tdata[CNT_W-1:0]));
          if (out_tdata[CNT_W+RGB_W-1:CNT_W] !== mon_expect.pixel)
            report_mismatch("read_data", 48'(mon_expect.pixel),
                            48'(out_tdata[CNT_W+RGB_W-1:CNT_W]));
          if (out_tdata[CNT_W+RGB_W] !== mon_expect.in_frame)
            report_mismatch("read_in_range", 48'(mon_expect.in_frame),
                            48'(out_tdata[CNT_W+RGB_W]));
        end
      end
      out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("alpha_blend_draw_engine verification failed");
      $finish;
    end
  end

  initial begin
    int k;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // full 256x256 frame at reset values; the clear defines every entry
    queue_cmd(make_cmd(abde_pkg::CMD_CLEAR, '0, '0, '0, '0, '0));
    queue_cmd(make_cmd(abde_pkg::CMD_READ, 16'd0, 16'd0, '0, '0, '0));
    queue_cmd(make_cmd(abde_pkg::CMD_READ, 16'd255, 16'd255, 16'hffff, 16'hffff, '1));
    queue_cmd(make_cmd(abde_pkg::CMD_READ, 16'd256, 16'd0, '0, '0, '0));
    queue_cmd(make_cmd(abde_pkg::CMD_READ, 16'd0, 16'hffff, '0, '0, '0));
    queue_cmd(make_cmd(abde_pkg::CMD_HLINE, 16'd0, 16'd0, 16'hffff, '0, 32'h80102030));
    queue_cmd(make_cmd(abde_pkg::CMD_HLINE, 16'd250, 16'd255, 16'd10, '0, 32'hff00ff00));
    queue_cmd(make_cmd(abde_pkg::CMD_HLINE, 16'd256, 16'd3, 16'd5, '0, 32'hff123456));
    queue_cmd(make_cmd(abde_pkg::CMD_HLINE, 16'd257, 16'd3, 16'd5, '0, 32'hff123456));
    queue_cmd(make_cmd(abde_pkg::CMD_VLINE, 16'd255, 16'd250, '0, 16'd20, 32'h00abcdef));
    queue_cmd(make_cmd(abde_pkg::CMD_VLINE, 16'd3, 16'd256, '0, 16'd4, 32'hff000000));
    queue_cmd(make_cmd(abde_pkg::CMD_VLINE, 16'hffff, 16'd0, '0, 16'd4, 32'hff000000));
    queue_cmd(make_cmd(abde_pkg::CMD_OUTLINE, 16'd10, 16'd10, 16'd5, 16'd4,
                       32'h40ff8001));
    queue_cmd(make_cmd(abde_pkg::CMD_OUTLINE, 16'd20, 16'd20, '0, '0, 32'hffffffff));
    queue_cmd(make_cmd(abde_pkg::CMD_OUTLINE, 16'd0, 16'd0, 16'd256, 16'd256,
                       32'hff0000ff));
    queue_cmd(make_cmd(abde_pkg::CMD_OUTLINE, 16'd250, 16'd250, 16'hffff, 16'hffff,
                       32'h7f5a5a5a));
    queue_cmd(make_cmd(abde_pkg::CMD_FILL, 16'd0, 16'd0, 16'hffff, 16'hffff,
                       32'h80c0ffee));
    queue_cmd(make_cmd(abde_pkg::CMD_FILL, 16'd256, 16'd0, 16'd4, 16'd4, 32'hff000000));
    queue_cmd(make_cmd(abde_pkg::CMD_FILL, 16'd100, 16'd100, 16'd3, 16'd2, 32'hc0224466));
    queue_cmd(make_cmd(abde_pkg::CMD_FILL, 16'd5, 16'd5, '0, 16'd7, 32'hffffffff));
    queue_cmd(make_cmd(abde_pkg::CMD_READ, 16'd10, 16'd10, '0, '0, '0));
    queue_cmd(make_cmd(abde_pkg::CMD_READ, 16'd101, 16'd101, '0, '0, '0));
    queue_cmd(make_cmd(CMD_SPARE_A, '1, '1, '1, '1, '1));
    queue_cmd(make_cmd(CMD_SPARE_B, COORD_W'($urandom), COORD_W'($urandom),
                       COORD_W'($urandom), COORD_W'($urandom), $urandom));
    queue_cmd(make_cmd(abde_pkg::CMD_READ, 16'hffff, 16'hffff, '0, '0, '0));
    wait_drained();

    // size extremes, zero size and saturating sizes
    run_phase(1, 1, 24'h000000, 30, 64, 1'b1);
    run_phase(256, 1, 24'hffffff, 30, 64, 1'b1);
    run_phase(1, 256, 24'h5a5a5a, 30, 64, 1'b1);
    run_phase(0, 9, 24'($urandom), 15, 64, 1'b1);
    run_phase(511, 3, 24'($urandom), 30, 64, 1'b1);
    run_phase(7, 300, 24'($urandom), 30, 64, 1'b1);

    for (k = 0; k < 6; k++) begin
      steady <= (k == 2);
      run_phase($urandom_range(32, 1), $urandom_range(32, 1), 24'($urandom), 35, 64, 1'b1);
    end
    steady <= 1'b0;

    // full frame again, mostly small shapes
    run_phase(256, 256, 24'($urandom), 20, 40, 1'b0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("alpha_blend_draw_engine verification clean");
    end else begin
      $display("alpha_blend_draw_engine verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/abde_pkg.sv
hdl/alpha_blend_draw_engine.sv
hdl/abde_checker.sv
sim/alpha_blend_draw_engine_tb.sv
